FILE: hw/rtl/ucfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucfp_pkg
// Shared types, command codes and sizes of the UART command frame parser.
// ----------------------------------------------------------------------------
package ucfp_pkg;

    // packet store size and derived widths
    localparam int PACKET_BYTES = 13;
    localparam int STORE_AW     = $clog2(PACKET_BYTES);
    localparam int WPOS_W       = $clog2(PACKET_BYTES + 1);
    localparam int EXP_W        = 8;
    localparam int PAYLOAD_LEN_W = 4;
    localparam int TICK_W       = 16;
    localparam int CFG_DATA_W   = 16;

    // result queue sizing
    localparam int RES_FIFO_DEPTH = 4;
    localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
    localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

    // framing bytes and command codes
    localparam logic [7:0] CODE_START    = 8'hAA;
    localparam logic [7:0] CODE_STOP     = 8'h55;
    localparam logic [7:0] CMD_NONE      = 8'h00;
    localparam logic [7:0] CMD_ACK       = 8'hA0;
    localparam logic [7:0] CMD_LEARN     = 8'hA1;
    localparam logic [7:0] CMD_SNIFF     = 8'hA4;
    localparam logic [7:0] CMD_TX_FIXED  = 8'hA5;
    localparam logic [7:0] CMD_SNIFF_ON  = 8'hA6;
    localparam logic [7:0] CMD_SNIFF_OFF = 8'hA7;
    localparam logic [7:0] CMD_TX_VAR    = 8'hA8;
    localparam logic [7:0] CMD_BEEP      = 8'hC0;
    localparam logic [7:0] CMD_FW_QUERY  = 8'hFF;

    localparam logic [EXP_W-1:0] FIXED_LEN = EXP_W'(9);
    localparam logic [EXP_W-1:0] BEEP_LEN  = EXP_W'(2);

    // timeout reset value
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(30000);

    // configuration register indexes
    localparam logic CFG_FW_VERSION = 1'b0;
    localparam logic CFG_TIMEOUT    = 1'b1;

    // result event codes
    typedef enum logic [1:0] {
        EV_SEND_BYTE = 2'd0,
        EV_TIMING_TX = 2'd1,
        EV_PROTO_TX  = 2'd2,
        EV_BEEP      = 2'd3
    } event_t;

    typedef struct packed {
        event_t                     event_res;
        logic [7:0]                 tx_byte;
        logic [15:0]                beep_ms;
        logic [PAYLOAD_LEN_W-1:0]   payload_length;
        logic                       last;
    } result_t;

    // results produced by one accepted item
    typedef struct packed {
        logic [1:0] res_cnt;
        result_t    res0;
        result_t    res1;
    } parse_out_t;

endpackage

FILE: hw/rtl/ucfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucfp_parser
// Frame state machine, packet store and result generation; one accepted item per clock.
// ----------------------------------------------------------------------------
module ucfp_parser import ucfp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_accept,
    input  logic                  kind,
    input  logic [7:0]            data_byte,
    input  logic [7:0]            fw_version,
    input  logic [TICK_W-1:0]     timeout_limit,
    output parse_out_t            parse_out
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SYNC   = 5'b00010,
        ST_LEN    = 5'b00100,
        ST_RECV   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [7:0]          cmd_reg, cmd_next;
    logic [WPOS_W-1:0]   wpos_reg, wpos_next;
    logic [EXP_W-1:0]    exp_reg, exp_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [7:0]          store_reg [PACKET_BYTES];

    logic [TICK_W-1:0]   tick_inc;
    logic [WPOS_W-1:0]   wpos_inc;
    logic                store_we;

    // saturating idle tick count and next write position
    assign tick_inc = (tick_reg == '1) ? tick_reg : tick_reg + 1'b1;
    assign wpos_inc = wpos_reg + 1'b1;
    assign store_we = item_accept && !kind && (state_reg == ST_RECV)
                      && (wpos_reg < WPOS_W'(PACKET_BYTES));

    // next state and results
    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        wpos_next  = wpos_reg;
        exp_next   = exp_reg;
        tick_next  = tick_reg;
        parse_out  = '0;
        if (item_accept) begin
            if (kind) begin
                // idle tick: timeout only counts outside idle
                if (state_reg == ST_IDLE) begin
                    tick_next = '0;
                end else begin
                    tick_next = tick_inc;
                    if (tick_inc > timeout_limit) begin
                        tick_next  = '0;
                        state_next = ST_IDLE;
                        cmd_next   = CMD_NONE;
                    end
                end
            end else begin
                tick_next = '0;
                unique case (state_reg)
                    ST_IDLE: begin
                        if (data_byte == CODE_START) begin
                            state_next = ST_SYNC;
                        end
                    end
                    ST_SYNC: begin
                        cmd_next = data_byte;
                        case (data_byte) inside
                            CMD_ACK, CMD_LEARN, CMD_SNIFF, CMD_SNIFF_ON,
                            CMD_SNIFF_OFF: begin
                                // keep waiting for a command byte
                            end
                            CMD_TX_FIXED: begin
                                wpos_next  = '0;
                                exp_next   = FIXED_LEN;
                                state_next = ST_RECV;
                            end
                            CMD_TX_VAR: begin
                                wpos_next  = '0;
                                state_next = ST_LEN;
                            end
                            CMD_BEEP: begin
                                wpos_next  = '0;
                                exp_next   = BEEP_LEN;
                                state_next = ST_RECV;
                            end
                            CMD_FW_QUERY: begin
                                parse_out.res_cnt           = 2'd2;
                                parse_out.res0.event_res    = EV_SEND_BYTE;
                                parse_out.res0.tx_byte      = CMD_ACK;
                                parse_out.res1.event_res    = EV_SEND_BYTE;
                                parse_out.res1.tx_byte      = fw_version;
                                parse_out.res1.last         = 1'b1;
                                state_next = ST_FINISH;
                            end
                            default: begin
                                state_next = ST_IDLE;
                                cmd_next   = CMD_NONE;
                            end
                        endcase
                    end
                    ST_LEN: begin
                        exp_next   = data_byte;
                        state_next = (data_byte != '0) ? ST_RECV : ST_FINISH;
                    end
                    ST_RECV: begin
                        wpos_next = wpos_inc;
                        if (EXP_W'(wpos_inc) == exp_reg) begin
                            state_next = ST_FINISH;
                        end else if (wpos_inc >= WPOS_W'(PACKET_BYTES)) begin
                            exp_next   = EXP_W'(PACKET_BYTES);
                            state_next = ST_FINISH;
                        end
                    end
                    ST_FINISH: begin
                        state_next = ST_IDLE;
                        if (data_byte == CODE_STOP) begin
                            case (cmd_reg)
                                CMD_TX_FIXED: begin
                                    parse_out.res_cnt             = 2'd1;
                                    parse_out.res0.event_res      = EV_TIMING_TX;
                                    parse_out.res0.payload_length =
                                        exp_reg[PAYLOAD_LEN_W-1:0];
                                    parse_out.res0.last           = 1'b1;
                                end
                                CMD_TX_VAR: begin
                                    parse_out.res_cnt             = 2'd1;
                                    parse_out.res0.event_res      = EV_PROTO_TX;
                                    parse_out.res0.payload_length =
                                        exp_reg[PAYLOAD_LEN_W-1:0];
                                    parse_out.res0.last           = 1'b1;
                                end
                                CMD_BEEP: begin
                                    parse_out.res_cnt             = 2'd2;
                                    parse_out.res0.event_res      = EV_BEEP;
                                    parse_out.res0.beep_ms        =
                                        {store_reg[0], store_reg[1]};
                                    parse_out.res0.payload_length =
                                        exp_reg[PAYLOAD_LEN_W-1:0];
                                    parse_out.res1.event_res      = EV_SEND_BYTE;
                                    parse_out.res1.tx_byte        = CMD_ACK;
                                    parse_out.res1.last           = 1'b1;
                                end
                                default: begin
                                    // stop without an action
                                end
                            endcase
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cmd_reg   <= CMD_NONE;
            wpos_reg  <= '0;
            exp_reg   <= '0;
            tick_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            wpos_reg  <= wpos_next;
            exp_reg   <= exp_next;
            tick_reg  <= tick_next;
        end
    end

    // packet store, no reset
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[wpos_reg[STORE_AW-1:0]] <= data_byte;
        end
    end

endmodule

FILE: hw/rtl/ucfp_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucfp_result_fifo
// Small result queue: takes up to two results per cycle, hands out one while m_ready is high.
// ----------------------------------------------------------------------------
module ucfp_result_fifo import ucfp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  parse_out_t push,
    output logic       has_room,
    output logic       m_valid,
    input  logic       m_ready,
    output result_t    m_result
);

    result_t                entry_reg [RES_FIFO_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0]   count_reg, count_next;
    logic                   pop;
    logic [RES_PTR_W-1:0]   wr_ptr_inc;

    assign pop        = m_valid && m_ready;
    assign m_valid    = (count_reg != '0);
    assign m_result   = entry_reg[rd_ptr_reg];
    // room for a full pair of results
    assign has_room   = (count_reg <= RES_CNT_W'(RES_FIFO_DEPTH - 2));
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push.res_cnt);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + RES_CNT_W'(push.res_cnt) - RES_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge aclk) begin
        if (push.res_cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.res_cnt == 2'd2) begin
            entry_reg[wr_ptr_inc] <= push.res1;
        end
    end

endmodule

FILE: hw/rtl/uart_command_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_command_frame_parser
// Parses framed UART command packets and emits send-byte, transmit and beep
// results.
// ----------------------------------------------------------------------------
// Each item (a received byte or an idle tick) is handled in the cycle it is
// accepted: the frame state machine updates at that edge and any results go
// into a four-entry result queue that drives the m_ channel from registers.
// The input takes one item per cycle as long as the queue has room for two
// results; results leave one per cycle while m_ready is high, and an item that
// answers with two results (firmware query, beep) queues both. Configuration
// writes take effect at the next edge; there is no start-up sweep.
// ----------------------------------------------------------------------------
module uart_command_frame_parser import ucfp_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    // input items
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_kind,
    input  logic [7:0]                s_data_byte,
    // results
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_event_res,
    output logic [7:0]                m_tx_byte,
    output logic [15:0]               m_beep_ms,
    output logic [PAYLOAD_LEN_W-1:0]  m_payload_length,
    output logic                      m_last
);

    logic [7:0]         fw_version_reg;
    logic [TICK_W-1:0]  timeout_limit_reg;
    logic               item_accept;
    parse_out_t         parse_out;
    result_t            m_result;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_version_reg    <= '0;
            timeout_limit_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FW_VERSION: fw_version_reg    <= cfg_wdata[7:0];
                CFG_TIMEOUT:    timeout_limit_reg <= cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign item_accept = s_valid && s_ready;

    ucfp_parser u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .item_accept      (item_accept),
        .kind             (s_kind),
        .data_byte        (s_data_byte),
        .fw_version       (fw_version_reg),
        .timeout_limit    (timeout_limit_reg),
        .parse_out        (parse_out)
    );

    ucfp_result_fifo u_result_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (parse_out),
        .has_room (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // result fields
    assign m_event_res      = m_result.event_res;
    assign m_tx_byte        = m_result.tx_byte;
    assign m_beep_ms        = m_result.beep_ms;
    assign m_payload_length = m_result.payload_length;
    assign m_last           = m_result.last;

    // an idle tick never yields a result
    a_tick_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_accept && s_kind) |-> (parse_out.res_cnt == 2'd0))
        else $error("idle tick produced a result");

    // a beep is always followed by its ack, so it is never the last result
    a_beep_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_res == EV_BEEP)) |-> !m_last)
        else $error("beep result marked last");

    // transmit lengths never exceed the packet store
    a_tx_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((m_event_res == EV_TIMING_TX) || (m_event_res == EV_PROTO_TX)))
        |-> (m_payload_length <= PAYLOAD_LEN_W'(PACKET_BYTES)))
        else $error("transmit length beyond packet store");

endmodule
